FILE: rtl/dlis_pkg.sv
// Shared types, constants and tables for the daily light and irrigation scheduler.
`default_nettype none
package dlis_pkg;

   localparam int unsigned MAX_EVENTS  = 24;
   localparam int unsigned EVT_IDX_W   = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
   localparam int unsigned CNT_W       = 5;
   localparam int unsigned MIN_PER_DAY = 24 * 60;
   localparam int unsigned MS_PER_SEC  = 1000;
   localparam int unsigned MIN_PER_HR  = 60;
   localparam int unsigned EVT_LIMIT   = (MAX_EVENTS < 24) ? MAX_EVENTS : 24;

   // Reciprocal of 1000 scaled by 2^38, rounded up: (x * DIV_K_MUL) >> 38 == x / 1000
   // for every 32-bit x
   localparam logic [28:0] DIV_K_MUL   = 29'd274877907;

   localparam int unsigned REQ_TDATA_W = 56;
   localparam int unsigned RSP_TDATA_W = 64;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 17;

   // Configuration reset values
   localparam logic [16:0] LIGHT_MIN_RST  = 17'd43200;
   localparam logic [4:0]  IRR_COUNT_RST  = 5'd3;
   localparam logic [15:0] IRR_DUR_RST    = 16'd60;
   localparam logic [4:0]  IRR_HOUR_RST   = 5'd6;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LIGHT_MIN  = 8'd0,
      REG_IRR_COUNT  = 8'd1,
      REG_IRR_DUR    = 8'd2,
      REG_IRR_HOUR   = 8'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ACCUM,
      ST_DAY,
      ST_EVENTS,
      ST_FINISH
   } state_type;

   // Minutes between evenly spaced events for a given event count
   function automatic logic [10:0] event_interval(input logic [4:0] count);
      logic [10:0] ivl;
      case (count)
         5'd1:    ivl = 11'(MIN_PER_DAY / 1);
         5'd2:    ivl = 11'(MIN_PER_DAY / 2);
         5'd3:    ivl = 11'(MIN_PER_DAY / 3);
         5'd4:    ivl = 11'(MIN_PER_DAY / 4);
         5'd5:    ivl = 11'(MIN_PER_DAY / 5);
         5'd6:    ivl = 11'(MIN_PER_DAY / 6);
         5'd7:    ivl = 11'(MIN_PER_DAY / 7);
         5'd8:    ivl = 11'(MIN_PER_DAY / 8);
         5'd9:    ivl = 11'(MIN_PER_DAY / 9);
         5'd10:   ivl = 11'(MIN_PER_DAY / 10);
         5'd11:   ivl = 11'(MIN_PER_DAY / 11);
         5'd12:   ivl = 11'(MIN_PER_DAY / 12);
         5'd13:   ivl = 11'(MIN_PER_DAY / 13);
         5'd14:   ivl = 11'(MIN_PER_DAY / 14);
         5'd15:   ivl = 11'(MIN_PER_DAY / 15);
         5'd16:   ivl = 11'(MIN_PER_DAY / 16);
         5'd17:   ivl = 11'(MIN_PER_DAY / 17);
         5'd18:   ivl = 11'(MIN_PER_DAY / 18);
         5'd19:   ivl = 11'(MIN_PER_DAY / 19);
         5'd20:   ivl = 11'(MIN_PER_DAY / 20);
         5'd21:   ivl = 11'(MIN_PER_DAY / 21);
         5'd22:   ivl = 11'(MIN_PER_DAY / 22);
         5'd23:   ivl = 11'(MIN_PER_DAY / 23);
         5'd24:   ivl = 11'(MIN_PER_DAY / 24);
         default: ivl = 11'd0;
      endcase
      return ivl;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/daily_light_and_irrigation_scheduler.sv
// Top level of the daily light and irrigation scheduler: sequencer and shared datapath.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  req     | in  | req_tvalid/tready  | req_tdata: tick (time stamp, lights, calendar)
//  rsp     | out | rsp_tvalid/tready  | rsp_tdata: relay, lights enforce, day history
//  csr     | in  | csr_valid/ready    | csr_index, csr_data: register write
//
// A tick passes from accept to the earliest result beat and to the next accept through
// these steps: one reciprocal multiply for the divide by 1000 of the elapsed milliseconds,
// one accumulate step, one day-change step, one step per irrigation event through the
// shared compare and add unit and one output load step. The first tick or an unchanged
// time stamp go straight to the output load; an invalid clock skips day change and events.
// req_tready is high only while the sequencer is idle; a result held in the output
// register does not stall the next accept, only the next result.
// Reset is synchronous and clears all control state; no clearing pass is needed.
`default_nettype none
module daily_light_and_irrigation_scheduler (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [31:0] now_ms, [32] lights_on, [33] time_valid, [42:34] day_of_year,
   // [47:43] hour_of_day, [53:48] minute_of_hour, [55:54] zero
   input  wire logic [dlis_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [0] relay_on, [1] relay_off, [2] lights_enforce, [19:3] lights_hold_sec,
   // [20] history_valid, [29:21] history_day, [61:30] history_light_sec, [63:62] zero
   output logic [dlis_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [dlis_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [dlis_pkg::CSR_DATA_W-1:0]      csr_data
);
   import dlis_pkg::*;

   // Sequencer
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // Configuration registers
   logic [16:0]          light_min_ff;
   logic [4:0]           irr_count_ff;
   logic [15:0]          irr_dur_ff;
   logic [4:0]           irr_hour_ff;

   // Latched tick fields
   logic [31:0]          now_ff;
   logic                 lights_ff;
   logic                 tvalid_ff;
   logic [8:0]           day_ff;
   logic [10:0]          now_min_ff;

   // Persistent state
   logic                 started_ff;
   logic [31:0]          last_tick_ff;
   logic [31:0]          total_ff;
   logic                 day_known_ff;
   logic [8:0]           last_day_ff;
   logic [MAX_EVENTS-1:0] fired_known_ff;
   logic [MAX_EVENTS-1:0] armed_ff;
   logic [8:0]           fired_day_ff [MAX_EVENTS];
   logic [31:0]          deadline_ff  [MAX_EVENTS];

   // Shared datapath registers
   logic [31:0]          quo_ff, quo_in;
   logic [25:0]          dur_ms_ff;
   logic [10:0]          acc_min_ff, acc_min_in;

   // Result under construction and output register
   logic                 res_on_ff, res_off_ff, res_enf_ff, res_hist_ff;
   logic [16:0]          res_hold_ff;
   logic [8:0]           res_hday_ff;
   logic [31:0]          res_hsec_ff;
   logic                 rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   // Decoded input fields
   logic [31:0]          in_now;
   logic                 in_lights;
   logic                 in_tvalid;
   logic [8:0]           in_day;
   logic [4:0]           in_hour;
   logic [5:0]           in_minute;
   logic [31:0]          in_delta;
   logic                 req_beat;
   logic                 csr_beat;

   // Datapath helpers
   logic [60:0]          div_prod;
   logic [32:0]          sat_sum;
   logic                 day_change;
   logic                 below_min;
   logic [EVT_IDX_W-1:0] evt;
   logic                 evt_last;
   logic                 evt_fire;
   logic                 evt_off;
   logic [31:0]          evt_gap;
   logic [11:0]          acc_next;
   logic                 finish_go;

   assign in_now    = req_tdata[31:0];
   assign in_lights = req_tdata[32];
   assign in_tvalid = req_tdata[33];
   assign in_day    = req_tdata[42:34];
   assign in_hour   = req_tdata[47:43];
   assign in_minute = req_tdata[53:48];
   assign in_delta  = in_now - last_tick_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign csr_beat   = csr_valid & csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Whole seconds by reciprocal multiply: load the delta, then replace it by the quotient
   assign div_prod = {29'd0, quo_ff} * {32'd0, DIV_K_MUL};
   always_comb begin
      case (state_ff)
         ST_IDLE:   quo_in = in_delta;
         ST_DIVIDE: quo_in = {9'd0, div_prod[60:38]};
         default:   quo_in = quo_ff;
      endcase
   end

   // Saturating light total and day checks
   assign sat_sum    = {1'b0, total_ff} + {1'b0, quo_ff};
   assign day_change = !day_known_ff || (last_day_ff != day_ff);
   assign below_min  = (total_ff < {15'd0, light_min_ff});

   // One irrigation event per cycle through the shared compare and add
   assign evt      = cnt_ff[EVT_IDX_W-1:0];
   assign evt_last = (cnt_ff == irr_count_ff - 5'd1);
   assign evt_fire = !(fired_known_ff[evt] && (fired_day_ff[evt] == day_ff))
                     && (acc_min_ff == now_min_ff);
   assign evt_gap  = now_ff - deadline_ff[evt];
   assign evt_off  = !evt_fire && armed_ff[evt] && !evt_gap[31];
   assign acc_next = {1'b0, acc_min_ff} + {1'b0, event_interval(irr_count_ff)};
   assign acc_min_in = (acc_next >= 12'(MIN_PER_DAY))
                       ? 11'(acc_next - 12'(MIN_PER_DAY)) : acc_next[10:0];

   assign finish_go = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (!started_ff || (in_delta == 32'd0)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            state_in = tvalid_ff ? ST_DAY : ST_FINISH;
         end
         ST_DAY: begin
            state_in = (irr_count_ff == 5'd0) ? ST_FINISH : ST_EVENTS;
         end
         ST_EVENTS: begin
            if (evt_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Step counter
   always_comb begin
      case (state_ff)
         ST_EVENTS: cnt_in = cnt_ff + CNT_W'(1);
         default:   cnt_in = '0;
      endcase
   end

   // Sequencer and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         started_ff     <= 1'b0;
         last_tick_ff   <= '0;
         total_ff       <= '0;
         day_known_ff   <= 1'b0;
         last_day_ff    <= '0;
         fired_known_ff <= '0;
         armed_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         light_min_ff   <= LIGHT_MIN_RST;
         irr_count_ff   <= IRR_COUNT_RST;
         irr_dur_ff     <= IRR_DUR_RST;
         irr_hour_ff    <= IRR_HOUR_RST;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;

         // Record the first tick, advance the time stamp on later ones
         if (req_beat) begin
            if (!started_ff) begin
               started_ff   <= 1'b1;
               last_tick_ff <= in_now;
               if (in_tvalid) begin
                  day_known_ff <= 1'b1;
                  last_day_ff  <= in_day;
               end
            end else if (in_delta != 32'd0) begin
               last_tick_ff <= in_now;
            end
         end

         // Accumulate whole seconds while lights are on
         if ((state_ff == ST_ACCUM) && lights_ff) begin
            total_ff <= sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
         end

         // Close the day
         if ((state_ff == ST_DAY) && day_change) begin
            total_ff       <= '0;
            day_known_ff   <= 1'b1;
            last_day_ff    <= day_ff;
            fired_known_ff <= '0;
         end

         // Fire or expire one event
         if (state_ff == ST_EVENTS) begin
            if (evt_fire) begin
               armed_ff[evt]       <= 1'b1;
               fired_known_ff[evt] <= 1'b1;
            end else if (evt_off) begin
               armed_ff[evt] <= 1'b0;
            end
         end

         // Hold the result until the sink takes the beat
         if ((state_ff == ST_FINISH) && finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         // Register writes; accepted irrigation writes drop all fired and armed marks
         if (csr_beat) begin
            case (csr_index)
               REG_LIGHT_MIN: light_min_ff <= csr_data[16:0];
               REG_IRR_COUNT: begin
                  if (csr_data[4:0] <= 5'(EVT_LIMIT)) begin
                     irr_count_ff   <= csr_data[4:0];
                     fired_known_ff <= '0;
                     armed_ff       <= '0;
                  end
               end
               REG_IRR_DUR: begin
                  if (csr_data[15:0] != 16'd0) begin
                     irr_dur_ff     <= csr_data[15:0];
                     fired_known_ff <= '0;
                     armed_ff       <= '0;
                  end
               end
               REG_IRR_HOUR: begin
                  irr_hour_ff    <= (csr_data[4:0] >= 5'd24) ? csr_data[4:0] - 5'd24
                                                             : csr_data[4:0];
                  fired_known_ff <= '0;
                  armed_ff       <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;

      if (req_beat) begin
         now_ff      <= in_now;
         lights_ff   <= in_lights;
         tvalid_ff   <= in_tvalid;
         day_ff      <= in_day;
         now_min_ff  <= 11'({6'd0, in_hour} * 11'(MIN_PER_HR)) + {5'd0, in_minute};
         res_on_ff   <= 1'b0;
         res_off_ff  <= 1'b0;
         res_enf_ff  <= 1'b0;
         res_hold_ff <= '0;
         res_hist_ff <= 1'b0;
         res_hday_ff <= '0;
         res_hsec_ff <= '0;
      end

      // Relay on-time in milliseconds for this tick
      if (state_ff == ST_ACCUM) begin
         dur_ms_ff <= 26'({10'd0, irr_dur_ff} * 26'(MS_PER_SEC));
      end

      // Report the finished day and enforce the light minimum
      if (state_ff == ST_DAY) begin
         acc_min_ff <= 11'({6'd0, irr_hour_ff} * 11'(MIN_PER_HR));
         if (day_change) begin
            if (day_known_ff) begin
               res_hist_ff <= 1'b1;
               res_hday_ff <= last_day_ff;
               res_hsec_ff <= total_ff;
            end
            if (below_min) begin
               res_enf_ff  <= 1'b1;
               res_hold_ff <= light_min_ff - total_ff[16:0];
            end
         end
      end

      if (state_ff == ST_EVENTS) begin
         acc_min_ff <= acc_min_in;
         if (evt_fire) begin
            res_on_ff <= 1'b1;
         end
         if (evt_off) begin
            res_off_ff <= 1'b1;
         end
      end

      // Load the output register
      if ((state_ff == ST_FINISH) && finish_go) begin
         rsp_data_ff <= {2'b00, res_hsec_ff, res_hday_ff, res_hist_ff, res_hold_ff,
                         res_enf_ff, res_off_ff, res_on_ff};
      end
   end

   // Per-event stores
   always_ff @(posedge clock) begin
      if ((state_ff == ST_EVENTS) && evt_fire) begin
         fired_day_ff[evt] <= day_ff;
         deadline_ff[evt]  <= now_ff + {6'd0, dur_ms_ff};
      end
   end

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the daily light and irrigation scheduler: directed, saturation and random ticks.
`timescale 1ns / 100ps

module testbench;
   import dlis_pkg::*;

   localparam int unsigned HOURS_PER_DAY = 24;
   localparam int unsigned SEC_PER_HR    = 3600;
   localparam int unsigned SEC_PER_DAY   = 86400;
   localparam int unsigned DAYS_PER_YEAR = 366;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned DRAIN_CYCLES  = 64;
   localparam int unsigned SAT_TICKS     = 1010;
   localparam int unsigned SEGMENTS      = 20;
   localparam int unsigned SEG_TICKS     = 14;
   localparam int unsigned MAX_PRINTS    = 40;

   // Register indexes the block does not decode
   localparam logic [CSR_INDEX_W-1:0] REG_UNKNOWN     = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_UNKNOWN_TOP = 8'hFF;

   typedef enum logic {OP_TICK, OP_CSR} op_kind_t;

   // One tick, packed in the same order as req_tdata
   typedef struct packed {
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [8:0]  day;
      logic        time_ok;
      logic        lights;
      logic [31:0] now_ms;
   } tick_t;

   // One schedule result, packed in the same order as rsp_tdata
   typedef struct packed {
      logic [31:0] hist_sec;
      logic [8:0]  hist_day;
      logic        hist_valid;
      logic [16:0] hold_sec;
      logic        enforce;
      logic        relay_off;
      logic        relay_on;
   } sched_out_t;

   typedef struct packed {
      op_kind_t                kind;
      logic [CSR_INDEX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0]   reg_val;
      tick_t                   tick;
      logic                    typed;
      sched_out_t              want;
   } stim_row_t;

   localparam sched_out_t NO_RESULT = '0;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   wire                      req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata  = '0;
   wire                      rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   wire  [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     csr_valid  = 1'b0;
   wire                      csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]    csr_data   = '0;

   int unsigned snd_idle = 21;
   int unsigned rcv_idle = 59;
   int unsigned mismatches = 0;

   sched_out_t outputs_due[$];
   stim_row_t  stim_rows[$];

   // Scheduler shadow: configuration and state
   logic [16:0]           cfg_light_min;
   logic [4:0]            cfg_irr_count;
   logic [15:0]           cfg_irr_dur;
   logic [4:0]            cfg_irr_hour;
   logic                  seen_tick;
   logic [31:0]           prev_ms;
   logic [31:0]           light_sec;
   logic                  day_known;
   logic [8:0]            prev_day;
   logic [10:0]           ev_minute   [MAX_EVENTS];
   logic [MAX_EVENTS-1:0] ev_fired_known;
   logic [8:0]            ev_fired_day [MAX_EVENTS];
   logic [MAX_EVENTS-1:0] ev_armed;
   logic [31:0]           ev_deadline [MAX_EVENTS];

   // Calendar the random ticks walk along
   logic [31:0] gen_ms;
   int unsigned gen_day;
   int unsigned gen_sec;

   daily_light_and_irrigation_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Spread the irrigation events over the day and disarm everything
   task automatic rebuild_event_minutes();
      int unsigned gap;
      int unsigned base;
      int i;
      gap  = (cfg_irr_count != 0) ? MIN_PER_DAY / cfg_irr_count : 0;
      base = cfg_irr_hour * MIN_PER_HR;
      for (i = 0; i < MAX_EVENTS; i++) begin
         ev_minute[i]      = (i < cfg_irr_count) ? 11'((base + i * gap) % MIN_PER_DAY) : '0;
         ev_fired_known[i] = 1'b0;
         ev_fired_day[i]   = '0;
         ev_armed[i]       = 1'b0;
         ev_deadline[i]    = '0;
      end
   endtask

   task automatic schedule_reset();
      cfg_light_min = LIGHT_MIN_RST;
      cfg_irr_count = IRR_COUNT_RST;
      cfg_irr_dur   = IRR_DUR_RST;
      cfg_irr_hour  = IRR_HOUR_RST;
      seen_tick     = 1'b0;
      prev_ms       = '0;
      light_sec     = '0;
      day_known     = 1'b0;
      prev_day      = '0;
      rebuild_event_minutes();
   endtask

   // Apply one register write to the shadow configuration
   task automatic schedule_write(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_LIGHT_MIN: cfg_light_min = val;
         REG_IRR_COUNT: begin
            if (val[4:0] <= EVT_LIMIT) begin
               cfg_irr_count = val[4:0];
               rebuild_event_minutes();
            end
         end
         REG_IRR_DUR: begin
            if (val[15:0] != 0) begin
               cfg_irr_dur = val[15:0];
               rebuild_event_minutes();
            end
         end
         REG_IRR_HOUR: begin
            cfg_irr_hour = 5'(val[4:0] % HOURS_PER_DAY);
            rebuild_event_minutes();
         end
         default: ;
      endcase
   endtask

   // Work out the result of one tick and advance the shadow state
   task automatic schedule_tick(input tick_t t, output sched_out_t r);
      logic [31:0] delta;
      logic [31:0] secs;
      int unsigned now_min;
      int i;
      r = '0;
      if (!seen_tick) begin
         seen_tick = 1'b1;
         prev_ms   = t.now_ms;
         if (t.time_ok) begin
            day_known = 1'b1;
            prev_day  = t.day;
         end
         return;
      end
      delta = t.now_ms - prev_ms;
      if (delta == 0)
         return;
      prev_ms = t.now_ms;

      // Accumulate whole seconds of light, saturating
      if (t.lights) begin
         secs = delta / MS_PER_SEC;
         if (light_sec > 32'hFFFF_FFFF - secs)
            light_sec = 32'hFFFF_FFFF;
         else
            light_sec = light_sec + secs;
      end
      if (!t.time_ok)
         return;

      // Close the previous day
      if (!day_known || prev_day != t.day) begin
         if (day_known) begin
            r.hist_valid = 1'b1;
            r.hist_day   = prev_day;
            r.hist_sec   = light_sec;
         end
         if (light_sec < cfg_light_min) begin
            r.enforce  = 1'b1;
            r.hold_sec = 17'(cfg_light_min - light_sec);
         end
         light_sec      = '0;
         day_known      = 1'b1;
         prev_day       = t.day;
         ev_fired_known = '0;
      end

      // Fire events due this minute, then retire expired deadlines
      now_min = int'(t.hour) * MIN_PER_HR + int'(t.minute);
      for (i = 0; i < cfg_irr_count && i < MAX_EVENTS; i++) begin
         if (ev_fired_known[i] && ev_fired_day[i] == t.day)
            continue;
         if (ev_minute[i] == now_min) begin
            r.relay_on        = 1'b1;
            ev_deadline[i]    = t.now_ms + 32'(cfg_irr_dur) * MS_PER_SEC;
            ev_armed[i]       = 1'b1;
            ev_fired_known[i] = 1'b1;
            ev_fired_day[i]   = t.day;
         end
      end
      for (i = 0; i < cfg_irr_count && i < MAX_EVENTS; i++) begin
         if (ev_armed[i] && ((t.now_ms - ev_deadline[i]) & 32'h8000_0000) == 0) begin
            r.relay_off    = 1'b1;
            ev_armed[i]    = 1'b0;
            ev_deadline[i] = '0;
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Append one row to the directed table
   task automatic add_row(input stim_row_t row);
      stim_rows = {stim_rows, row};
   endtask

   // Present one tick, record its expected result on the accepting edge
   task automatic send_tick(input tick_t t, input logic typed = 1'b0,
                            input sched_out_t want = '0);
      sched_out_t r;
      @(negedge clock);
      while ($urandom_range(0, 99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {2'b00, t};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      schedule_tick(t, r);
      if (typed)
         r = want;
      outputs_due = {outputs_due, r};
   endtask

   // Hold off the sender until every expected result has come back
   task automatic hold_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outputs_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      hold_until_drained();
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      schedule_write(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_random_reg();
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  val;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      idx  = (pick < 6) ? 8'($urandom_range(4, 255)) : 8'($urandom_range(0, 3));
      val  = 17'($urandom);
      pick = $urandom_range(0, 9);
      case (idx)
         REG_LIGHT_MIN: begin
            if (pick == 0)
               val = '0;
            else if (pick == 1)
               val = 17'(SEC_PER_DAY);
            else if (pick == 2)
               val = '1;
            else
               val = 17'($urandom_range(0, SEC_PER_DAY));
         end
         REG_IRR_COUNT: begin
            val[4:0] = (pick == 0) ? 5'($urandom_range(25, 31)) : 5'($urandom_range(0, 24));
         end
         REG_IRR_DUR: begin
            if (pick == 0)
               val[15:0] = '0;
            else if (pick == 1)
               val[15:0] = '1;
            else if (pick == 2)
               val[15:0] = 16'($urandom);
            else
               val[15:0] = 16'($urandom_range(1, 90));
         end
         default: ;
      endcase
      write_reg(idx, val);
   endtask

   function automatic stim_row_t tick_row(input logic [31:0] now_ms, input logic lights,
                                          input logic time_ok, input logic [8:0] day,
                                          input logic [4:0] hour, input logic [5:0] minute,
                                          input logic typed = 1'b0,
                                          input sched_out_t want = '0);
      stim_row_t r;
      r              = '0;
      r.kind         = OP_TICK;
      r.tick.now_ms  = now_ms;
      r.tick.lights  = lights;
      r.tick.time_ok = time_ok;
      r.tick.day     = day;
      r.tick.hour    = hour;
      r.tick.minute  = minute;
      r.typed        = typed;
      r.want         = want;
      return r;
   endfunction

   function automatic stim_row_t csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] val);
      stim_row_t r;
      r         = '0;
      r.kind    = OP_CSR;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   // Walk the calendar forward by some milliseconds
   task automatic gen_advance(input int unsigned ms);
      gen_ms  = gen_ms + ms;
      gen_sec = gen_sec + ms / MS_PER_SEC;
      while (gen_sec >= SEC_PER_DAY) begin
         gen_sec = gen_sec - SEC_PER_DAY;
         gen_day = (gen_day + 1) % DAYS_PER_YEAR;
      end
   endtask

   function automatic tick_t gen_tick(input logic lights, input logic time_ok);
      tick_t t;
      t.now_ms  = gen_ms;
      t.lights  = lights;
      t.time_ok = time_ok;
      t.day     = 9'(gen_day);
      t.hour    = 5'(gen_sec / SEC_PER_HR);
      t.minute  = 6'((gen_sec / MIN_PER_HR) % MIN_PER_HR);
      return t;
   endfunction

   // Mostly a well-formed walk toward event minutes, deadlines and day
   // boundaries, with some invalid-time, unchanged and noise ticks
   task automatic make_tick(output tick_t t);
      int unsigned pick;
      int unsigned target;
      int unsigned adv_ms;
      logic        time_ok;
      pick    = $urandom_range(0, 99);
      time_ok = 1'b1;
      adv_ms  = 0;
      if (pick < 40) begin
         adv_ms = $urandom_range(1000, 30000);
      end else if (pick < 58) begin
         if (cfg_irr_count != 0) begin
            target = ev_minute[$urandom_range(0, cfg_irr_count - 1)] * MIN_PER_HR
                     + $urandom_range(0, 20);
            adv_ms = (target > gen_sec) ? target - gen_sec : target + SEC_PER_DAY - gen_sec;
            adv_ms = adv_ms * MS_PER_SEC + $urandom_range(0, 999);
         end else begin
            adv_ms = $urandom_range(1000, 600000);
         end
      end else if (pick < 68) begin
         adv_ms = 32'(cfg_irr_dur) * MS_PER_SEC + $urandom_range(0, 2000) - 1000;
      end else if (pick < 73) begin
         adv_ms = (SEC_PER_DAY - gen_sec) * MS_PER_SEC + $urandom_range(0, 3600000);
      end else if (pick < 78) begin
         adv_ms = 0;
      end else if (pick < 83) begin
         time_ok = 1'b0;
         adv_ms  = $urandom_range(1, 120000);
      end else if (pick < 90) begin
         adv_ms = $urandom_range(1, 999);
      end
      if (pick >= 90) begin
         t.now_ms  = $urandom;
         t.lights  = 1'($urandom);
         t.time_ok = 1'($urandom);
         t.day     = 9'($urandom);
         t.hour    = 5'($urandom);
         t.minute  = 6'($urandom);
      end else begin
         gen_advance(adv_ms);
         t = gen_tick(1'($urandom), time_ok);
      end
   endtask

   // Randomly back-pressure the result channel
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rcv_idle);
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      sched_out_t got;
      sched_out_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = sched_out_t'(rsp_tdata[61:0]);
         if (outputs_due.size() == 0) begin
            report_mismatch($sformatf("result beat 0x%0h with nothing expected", rsp_tdata));
         end else begin
            want = outputs_due.pop_front();
            check_field("relay_on", got.relay_on, want.relay_on);
            check_field("relay_off", got.relay_off, want.relay_off);
            check_field("lights_enforce", got.enforce, want.enforce);
            check_field("lights_hold_sec", got.hold_sec, want.hold_sec);
            check_field("history_valid", got.hist_valid, want.hist_valid);
            check_field("history_day", got.hist_day, want.hist_day);
            check_field("history_light_sec", got.hist_sec, want.hist_sec);
         end
      end
   end

   // End the run when no beat moves for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      sched_out_t short_day;
      tick_t      t;
      int unsigned seg;
      int unsigned n;

      schedule_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty day closed against the largest minimum
      short_day            = '0;
      short_day.hist_valid = 1'b1;
      short_day.enforce    = 1'b1;
      short_day.hold_sec   = '1;

      // Directed: first tick without time, unchanged stamp, day opening,
      // event and deadline, out-of-range clock, register extremes, wrap
      add_row(tick_row(32'd1000, 1'b1, 1'b0, 9'd10, 5'd0, 6'd0, 1'b1, NO_RESULT));
      add_row(tick_row(32'd1000, 1'b1, 1'b1, 9'd10, 5'd0, 6'd0, 1'b1, NO_RESULT));
      add_row(tick_row(32'd3500, 1'b1, 1'b1, 9'd10, 5'd5, 6'd59));
      add_row(tick_row(32'd5000, 1'b1, 1'b1, 9'd10, 5'd6, 6'd0));
      add_row(tick_row(32'd40000, 1'b0, 1'b0, 9'd10, 5'd6, 6'd0, 1'b1, NO_RESULT));
      add_row(tick_row(32'd65000, 1'b0, 1'b1, 9'd10, 5'd6, 6'd1));
      add_row(tick_row(32'd66000, 1'b1, 1'b1, 9'd10, 5'd14, 6'd0));
      add_row(tick_row(32'd100000, 1'b0, 1'b1, 9'd11, 5'd31, 6'd63));
      add_row(csr_row(REG_LIGHT_MIN, 17'd0));
      add_row(csr_row(REG_IRR_COUNT, 17'd24));
      add_row(csr_row(REG_IRR_DUR, 17'd65535));
      add_row(csr_row(REG_IRR_HOUR, 17'd23));
      add_row(csr_row(REG_IRR_COUNT, 17'd25));
      add_row(csr_row(REG_IRR_DUR, 17'd0));
      add_row(csr_row(REG_IRR_HOUR, 17'd31));
      add_row(csr_row(REG_UNKNOWN, 17'h1FFFF));
      add_row(csr_row(REG_UNKNOWN_TOP, 17'd0));
      add_row(tick_row(32'hFFFF_FFFF, 1'b1, 1'b1, 9'd11, 5'd0, 6'd0));
      add_row(tick_row(32'h0000_0400, 1'b1, 1'b1, 9'd511, 5'd23, 6'd0));
      add_row(csr_row(REG_LIGHT_MIN, 17'h1FFFF));
      add_row(csr_row(REG_IRR_COUNT, 17'd0));
      add_row(tick_row(32'h8000_0400, 1'b1, 1'b1, 9'd0, 5'd6, 6'd0));
      add_row(tick_row(32'h8000_0600, 1'b0, 1'b1, 9'd1, 5'd6, 6'd0, 1'b1, short_day));

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == OP_CSR)
            write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
         else
            send_tick(stim_rows[i].tick, stim_rows[i].typed, stim_rows[i].want);
      end

      // Saturate the light total: lights on, nearly a full wrap per tick, one day
      gen_ms  = 32'h8000_0600;
      gen_day = 1;
      gen_sec = 12 * SEC_PER_HR;
      write_reg(REG_IRR_COUNT, 17'd24);
      write_reg(REG_IRR_DUR, 17'd30);
      repeat (SAT_TICKS) begin
         gen_ms = gen_ms - $urandom_range(1, 1000);
         t      = gen_tick(1'b1, ($urandom_range(0, 9) != 0));
         t.hour   = 5'($urandom_range(0, 23));
         t.minute = 6'($urandom_range(0, 59));
         send_tick(t);
      end
      gen_advance(SEC_PER_DAY * MS_PER_SEC);
      send_tick(gen_tick(1'b0, 1'b1));

      // Random segments, each behind a few register writes
      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 7) begin
            snd_idle = 21;
            rcv_idle = 59;
         end else if (seg < 14) begin
            snd_idle = 59;
            rcv_idle = 21;
         end else begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         repeat ($urandom_range(1, 3))
            write_random_reg();
         for (n = 0; n < SEG_TICKS; n++) begin
            if (seg == 10 && n == 7)
               hold_until_drained();
            make_tick(t);
            send_tick(t);
         end
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
